@@ hdl/pfu_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the posit field unpacker.
// No dependencies; every other file of the block imports this package.
package pfu_pkg;

  localparam int MAX_WIDTH_DEF = 32;
  localparam int MAX_ES_DEF    = 4;

  localparam int WORD_W      = 32;
  localparam int KIND_W      = 2;
  localparam int REGIME_W    = 6;
  localparam int EXPF_W      = 4;
  localparam int TEXP_W      = 10;
  localparam int FSIZE_W     = 5;
  localparam int FRAC_W      = 29;
  localparam int STATUS_W    = 2;

  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 6;
  localparam int PWIDTH_W    = 6;
  localparam int ESIZE_W     = 3;

  localparam logic [PWIDTH_W-1:0] PWIDTH_RESET = 6'd32;
  localparam logic [ESIZE_W-1:0]  ESIZE_RESET  = 3'd2;
  localparam logic [PWIDTH_W-1:0] PWIDTH_MIN   = 6'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POSIT_WIDTH = 1'b0,
    CFG_EXP_SIZE    = 1'b1
  } cfg_idx_e;

  typedef enum logic [KIND_W-1:0] {
    SK_ORDINARY = 2'd0,
    SK_ZERO     = 2'd1,
    SK_NAR      = 2'd2
  } special_kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_SPECIAL   = 2'd1,
    ST_MALFORMED = 2'd2
  } status_e;

endpackage

@@ hdl/pfu_channels.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for posit words in and unpacked fields out.
// Depends on pfu_pkg for the field widths.
interface pfu_word_if import pfu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] posit_word;

  modport source (output valid, output posit_word, input ready);
  modport sink   (input valid, input posit_word, output ready);
endinterface

interface pfu_result_if import pfu_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [KIND_W-1:0]          special_kind;
  logic                       negative;
  logic signed [REGIME_W-1:0] regime_k;
  logic [EXPF_W-1:0]          exponent_field;
  logic signed [TEXP_W-1:0]   total_exponent;
  logic [FSIZE_W-1:0]         fraction_size;
  logic [FRAC_W-1:0]          fraction_bits;
  logic [STATUS_W-1:0]        status;

  modport source (
    output valid, output special_kind, output negative, output regime_k,
    output exponent_field, output total_exponent, output fraction_size,
    output fraction_bits, output status, input ready
  );
  modport sink (
    input valid, input special_kind, input negative, input regime_k,
    input exponent_field, input total_exponent, input fraction_size,
    input fraction_bits, input status, output ready
  );
endinterface

@@ hdl/pfu_run_scan.sv @@
`timescale 1ns / 1ps
// Regime run scanner: finds the bit that ends the run of identical bits after the sign.
// Depends on pfu_pkg.
module pfu_run_scan import pfu_pkg::*; #(
  parameter int MaxWidth = MAX_WIDTH_DEF,
  localparam int IW  = $clog2(MaxWidth),
  localparam int PSW = IW + 1
) (
  input  logic [MaxWidth-1:0] word_i,
  input  logic [PSW-1:0]      ps_i,
  output logic                run_o,
  output logic                found_o,
  output logic [IW-1:0]       bi_o
);

  logic [PSW-1:0]      off;
  logic [MaxWidth-1:0] aligned;
  logic [MaxWidth-1:0] vmask;
  logic [MaxWidth-1:0] scan;
  logic [IW-1:0]       pos;

  always_comb begin
    off     = PSW'(MaxWidth) - ps_i;
    aligned = word_i << off;
    vmask   = {MaxWidth{1'b1}} << off;
    run_o   = aligned[MaxWidth-2];
    scan    = (run_o ? ~aligned : aligned) & vmask;
    found_o = 1'b0;
    pos     = '0;
    for (int j = 0; j < MaxWidth - 2; j++) begin
      if (scan[j]) begin
        found_o = 1'b1;
        pos     = IW'(j);
      end
    end
    bi_o = pos - off[IW-1:0];
  end

endmodule

@@ hdl/posit_field_unpacker.sv @@
`timescale 1ns / 1ps
// Top level of the posit field unpacker: four-stage pipeline and configuration registers.
// Depends on pfu_pkg, the channel interfaces and pfu_run_scan.
//
//   Channel   Direction  Handshake          Carries
//   word_i    in         valid / ready      posit_word
//   result_o  out        valid / ready      unpacked fields and status
//   cfg       in         cfg_we_i only      posit_width, exponent_size
//
// One item per cycle is accepted unless the output stalls with every stage full. An item
// passes through one register stage each for negate, regime scan, field extraction and
// total exponent, and the last of them drives the output.
// Reset clears the stage valid bits and sets the registers to width 32 and es 2.
// A stalled output holds each stage; a stage accepts new data whenever it is empty or
// the stage after it moves, so bubbles are squeezed out and nothing is lost or repeated.
module posit_field_unpacker import pfu_pkg::*; #(
  parameter int MaxWidth = MAX_WIDTH_DEF,
  parameter int MaxEs    = MAX_ES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  pfu_word_if.sink              word_i,
  pfu_result_if.source          result_o
);

  localparam int IW  = $clog2(MaxWidth);
  localparam int PSW = IW + 1;
  localparam int EW  = $clog2(MaxEs + 1);
  localparam int KW  = IW + 2;
  localparam int SW  = IW + 2;
  localparam int TW  = KW + MaxEs + 1;
  localparam logic signed [KW-1:0] KTwo   = KW'(2);
  localparam logic signed [KW-1:0] KThree = KW'(3);

  logic [PWIDTH_W-1:0] posit_width_q;
  logic [ESIZE_W-1:0]  exponent_size_q;
  logic [PSW-1:0]      ps_c;
  logic [EW-1:0]       es_c;
  logic [IW-1:0]       ps_top;
  logic [MaxWidth-1:0] ones;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      posit_width_q   <= PWIDTH_RESET;
      exponent_size_q <= ESIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_POSIT_WIDTH: posit_width_q   <= cfg_wdata_i[PWIDTH_W-1:0];
        CFG_EXP_SIZE:    exponent_size_q <= cfg_wdata_i[ESIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (posit_width_q < PWIDTH_MIN) begin
      ps_c = PSW'(PWIDTH_MIN);
    end else if (posit_width_q > PWIDTH_W'(MaxWidth)) begin
      ps_c = PSW'(MaxWidth);
    end else begin
      ps_c = posit_width_q[PSW-1:0];
    end
    if (exponent_size_q > ESIZE_W'(MaxEs)) begin
      es_c = EW'(MaxEs);
    end else begin
      es_c = exponent_size_q[EW-1:0];
    end
    ps_top = IW'(ps_c - PSW'(1));
    ones   = '1;
  end

  logic rdy1, rdy2, rdy3, rdy4;
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;

  assign rdy4 = !s4_v_q || result_o.ready;
  assign rdy3 = !s3_v_q || rdy4;
  assign rdy2 = !s2_v_q || rdy3;
  assign rdy1 = !s1_v_q || rdy2;
  assign word_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_v_q <= word_i.valid;
      end
      if (rdy2) begin
        s2_v_q <= s1_v_q;
      end
      if (rdy3) begin
        s3_v_q <= s2_v_q;
      end
      if (rdy4) begin
        s4_v_q <= s3_v_q;
      end
    end
  end

  // Stage 1: cut to width and take the magnitude.
  logic [MaxWidth-1:0] wmask;
  logic [MaxWidth-1:0] w_m;
  logic [MaxWidth-1:0] w_n;
  logic                sgn;
  logic [MaxWidth-1:0] s1_word_q;
  logic                s1_neg_q;

  always_comb begin
    wmask = ~(ones << ps_c);
    w_m   = word_i.posit_word[MaxWidth-1:0] & wmask;
    sgn   = w_m[ps_top];
    w_n   = sgn ? ((~w_m + MaxWidth'(1)) & wmask) : w_m;
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_word_q <= w_n;
      s1_neg_q  <= sgn;
    end
  end

  // Stage 2: special words and the regime run.
  logic                run_c, found_c;
  logic [IW-1:0]       bi_c;
  special_kind_e       kind_c;
  logic [MaxWidth-1:0] s2_word_q;
  logic                s2_neg_q;
  special_kind_e       s2_kind_q;
  logic                s2_one_q;
  logic                s2_run_q;
  logic                s2_biok_q;
  logic [IW-1:0]       s2_bi_q;

  pfu_run_scan #(
    .MaxWidth (MaxWidth)
  ) u_run_scan (
    .word_i  (s1_word_q),
    .ps_i    (ps_c),
    .run_o   (run_c),
    .found_o (found_c),
    .bi_o    (bi_c)
  );

  always_comb begin
    if (s1_word_q == '0) begin
      kind_c = SK_ZERO;
    end else if (s1_word_q == (MaxWidth'(1) << ps_top)) begin
      kind_c = SK_NAR;
    end else begin
      kind_c = SK_ORDINARY;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      s2_word_q <= s1_word_q;
      s2_neg_q  <= s1_neg_q;
      s2_kind_q <= kind_c;
      s2_one_q  <= (s1_word_q == MaxWidth'(1));
      s2_run_q  <= run_c;
      s2_biok_q <= found_c && (bi_c != '0);
      s2_bi_q   <= bi_c;
    end
  end

  // Stage 3: regime value, exponent bits and fraction.
  logic [IW-1:0]              b;
  logic signed [KW-1:0]       ps_s, b_s, k_c;
  logic [MaxWidth-1:0]        w_low;
  logic [MaxWidth+MaxEs-1:0]  ext;
  logic [SW-1:0]              sh;
  logic [MaxEs-1:0]           e_c;
  logic                       bi_ge, use_frac, malformed;
  logic [IW-1:0]              fs_c;
  logic [MaxWidth-1:0]        frac_c;
  status_e                    status_c;

  logic                       s3_neg_q;
  special_kind_e              s3_kind_q;
  status_e                    s3_status_q;
  logic signed [KW-1:0]       s3_k_q;
  logic [MaxEs-1:0]           s3_e_q;
  logic [IW-1:0]              s3_fs_q;
  logic [MaxWidth-1:0]        s3_frac_q;

  always_comb begin
    b        = s2_biok_q ? s2_bi_q : '0;
    ps_s     = signed'(KW'(ps_c));
    b_s      = signed'(KW'(b));
    k_c      = s2_run_q ? (ps_s - b_s - KThree) : (b_s - ps_s + KTwo);
    w_low    = s2_word_q & ~(ones << b);
    ext      = {w_low, {MaxEs{1'b0}}};
    sh       = SW'(b) + SW'(MaxEs) - SW'(es_c);
    e_c      = MaxEs'(ext >> sh);
    bi_ge    = (SW'(b) >= SW'(es_c));
    use_frac = s2_biok_q && bi_ge;
    fs_c     = use_frac ? IW'(SW'(b) - SW'(es_c)) : '0;
    frac_c   = use_frac ? (s2_word_q & ~(ones << fs_c)) : '0;
    malformed = (!s2_biok_q && !s2_one_q) || (s2_biok_q && !bi_ge);
    if (s2_kind_q != SK_ORDINARY) begin
      status_c = ST_SPECIAL;
      k_c      = '0;
      e_c      = '0;
      fs_c     = '0;
      frac_c   = '0;
    end else if (malformed) begin
      status_c = ST_MALFORMED;
    end else begin
      status_c = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      s3_neg_q    <= s2_neg_q;
      s3_kind_q   <= s2_kind_q;
      s3_status_q <= status_c;
      s3_k_q      <= k_c;
      s3_e_q      <= e_c;
      s3_fs_q     <= fs_c;
      s3_frac_q   <= frac_c;
    end
  end

  // Stage 4: total exponent and the output register.
  logic signed [TW-1:0]       texp_c;
  logic                       s4_neg_q;
  special_kind_e              s4_kind_q;
  status_e                    s4_status_q;
  logic signed [REGIME_W-1:0] s4_k_q;
  logic [EXPF_W-1:0]          s4_e_q;
  logic signed [TEXP_W-1:0]   s4_texp_q;
  logic [FSIZE_W-1:0]         s4_fs_q;
  logic [FRAC_W-1:0]          s4_frac_q;

  assign texp_c = (TW'(s3_k_q) <<< es_c) + signed'(TW'(s3_e_q));

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      s4_neg_q    <= s3_neg_q;
      s4_kind_q   <= s3_kind_q;
      s4_status_q <= s3_status_q;
      s4_k_q      <= REGIME_W'(s3_k_q);
      s4_e_q      <= EXPF_W'(s3_e_q);
      s4_texp_q   <= TEXP_W'(texp_c);
      s4_fs_q     <= FSIZE_W'(s3_fs_q);
      s4_frac_q   <= FRAC_W'(s3_frac_q);
    end
  end

  assign result_o.valid          = s4_v_q;
  assign result_o.special_kind   = s4_kind_q;
  assign result_o.negative       = s4_neg_q;
  assign result_o.regime_k       = s4_k_q;
  assign result_o.exponent_field = s4_e_q;
  assign result_o.total_exponent = s4_texp_q;
  assign result_o.fraction_size  = s4_fs_q;
  assign result_o.fraction_bits  = s4_frac_q;
  assign result_o.status         = s4_status_q;

  a_special_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |->
      ((result_o.status == ST_SPECIAL) == (result_o.special_kind != SK_ORDINARY)))
    else $error("special kind and status disagree");

  a_special_sign : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (result_o.special_kind != SK_ORDINARY)) |->
      (result_o.negative == (result_o.special_kind == SK_NAR)))
    else $error("sign of zero or NaR is wrong");

  a_frac_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> ((result_o.fraction_bits >> result_o.fraction_size) == '0))
    else $error("fraction bits exceed the fraction size");

  a_malformed_no_frac : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (result_o.status == ST_MALFORMED)) |->
      (result_o.fraction_size == '0))
    else $error("malformed item reports a fraction");

endmodule

@@ bench/tb_posit_field_unpacker.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for posit_field_unpacker: directed table, then random posit words.
// Depends on pfu_pkg, the pfu channel interfaces and the posit_field_unpacker RTL.
module tb_posit_field_unpacker;
  import pfu_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 8;
  localparam int DIR_N       = 25;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 120;

  typedef struct packed {
    special_kind_e         kind;
    logic                  neg;
    logic [REGIME_W-1:0]   regime;
    logic [EXPF_W-1:0]     expf;
    logic [TEXP_W-1:0]     texp;
    logic [FSIZE_W-1:0]    fsize;
    logic [FRAC_W-1:0]     frac;
    status_e               st;
  } fields_t;

  typedef struct {
    logic [CFG_DATA_W-1:0] pw;
    logic [CFG_DATA_W-1:0] esd;
    logic [WORD_W-1:0]     word;
    bit                    typed;
    fields_t               want;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  pfu_word_if   word_ch ();
  pfu_result_if res_ch ();

  posit_field_unpacker u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .word_i      (word_ch),
    .result_o    (res_ch)
  );

  fields_t               pending_fields[$];
  logic [CFG_DATA_W-1:0] cur_pw;
  logic [CFG_DATA_W-1:0] cur_esd;
  int                    mismatch_count;
  int                    cycle_count;
  int                    burst_left;
  dir_row_t              dir_rows [0:DIR_N-1];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic fields_t predict_fields(input logic [WORD_W-1:0] raw,
                                             input logic [CFG_DATA_W-1:0] pw,
                                             input logic [ESIZE_W-1:0] esr);
    fields_t     r;
    int          ps;
    int          es;
    int          k;
    int          e;
    int          texp;
    int          fs;
    int          bi;
    logic [63:0] mask;
    logic [63:0] w;
    logic [63:0] frac64;
    logic        run;
    ps = int'(pw);
    es = int'(esr);
    if (ps < 3) ps = 3;
    if (ps > 32) ps = 32;
    if (es > 4) es = 4;
    mask = (64'd1 << ps) - 64'd1;
    w = {32'd0, raw} & mask;
    r = '0;
    r.kind = SK_ORDINARY;
    r.st = ST_OK;
    k = 0;
    e = 0;
    texp = 0;
    fs = 0;
    if (w[ps-1]) begin
      r.neg = 1'b1;
      w = (~w + 64'd1) & mask;
    end
    if (w == 64'd0) begin
      r.kind = SK_ZERO;
      r.st = ST_SPECIAL;
    end else if (w == (64'd1 << (ps - 1))) begin
      r.kind = SK_NAR;
      r.st = ST_SPECIAL;
    end else if (w == 64'd1) begin
      k = -(ps - 2);
      texp = k * (1 << es);
    end else begin
      run = w[ps-2];
      bi = ps - 3;
      while (bi >= 0 && w[bi] == run) bi--;
      if (bi <= 0) begin
        k = run ? (ps - 3) : -(ps - 2);
        texp = k * (1 << es);
        r.st = ST_MALFORMED;
      end else begin
        k = run ? (ps - 3 - bi) : (bi - ps + 2);
        if (bi >= es) e = int'((w >> (bi - es)) & ((64'd1 << es) - 64'd1));
        else e = int'((w & ((64'd1 << bi) - 64'd1)) << (es - bi));
        texp = k * (1 << es) + e;
        fs = bi - es;
        if (fs < 0) begin
          fs = 0;
          r.st = ST_MALFORMED;
        end else begin
          frac64 = w & ((64'd1 << fs) - 64'd1);
          r.frac = frac64[FRAC_W-1:0];
        end
      end
    end
    r.regime = k[REGIME_W-1:0];
    r.expf = e[EXPF_W-1:0];
    r.texp = texp[TEXP_W-1:0];
    r.fsize = fs[FSIZE_W-1:0];
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch in %s: got %0h, expected %0h, cycle %0d", what, got, want,
             cycle_count);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_posit_field_unpacker: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    fields_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_fields.size() == 0) begin
        report("unexpected item", 1, 0);
      end else begin
        want = pending_fields.pop_front();
        if (res_ch.special_kind !== want.kind)
          report("special_kind", res_ch.special_kind, want.kind);
        if (res_ch.negative !== want.neg) report("negative", res_ch.negative, want.neg);
        if (res_ch.regime_k !== want.regime)
          report("regime_k", res_ch.regime_k, want.regime);
        if (res_ch.exponent_field !== want.expf)
          report("exponent_field", res_ch.exponent_field, want.expf);
        if (res_ch.total_exponent !== want.texp)
          report("total_exponent", res_ch.total_exponent, want.texp);
        if (res_ch.fraction_size !== want.fsize)
          report("fraction_size", res_ch.fraction_size, want.fsize);
        if (res_ch.fraction_bits !== want.frac)
          report("fraction_bits", res_ch.fraction_bits, want.frac);
        if (res_ch.status !== want.st) report("status", res_ch.status, want.st);
      end
    end
  end

  initial begin
    int mode;
    int len;
    res_ch.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(16, 96);
      repeat (len) begin
        @(posedge clk_i);
        case (mode)
          0: begin
            res_ch.ready <= 1'b1;
          end
          1: begin
            res_ch.ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            res_ch.ready <= ($urandom_range(0, 7) != 0);
          end
          default: begin
            res_ch.ready <= ($urandom_range(0, 15) == 0);
          end
        endcase
      end
    end
  end

  task automatic send(input logic [WORD_W-1:0] w, input fields_t want);
    word_ch.valid <= 1'b1;
    word_ch.posit_word <= w;
    do @(posedge clk_i); while (!word_ch.ready);
    pending_fields.push_back(want);
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      word_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
    end
  endtask

  task automatic drain();
    word_ch.valid <= 1'b0;
    while (pending_fields.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_DATA_W-1:0] pw,
                           input logic [CFG_DATA_W-1:0] esd);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_POSIT_WIDTH;
    cfg_wdata_i <= pw;
    @(posedge clk_i);
    cfg_idx_i <= CFG_EXP_SIZE;
    cfg_wdata_i <= esd;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_pw = pw;
    cur_esd = esd;
  endtask

  initial begin
    logic [WORD_W-1:0]     w;
    logic [WORD_W-1:0]     cand;
    logic [WORD_W-1:0]     m;
    logic [63:0]           m64;
    logic [CFG_DATA_W-1:0] pw;
    int                    ps_eff;
    int                    sh;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_POSIT_WIDTH;
    cfg_wdata_i <= '0;
    word_ch.valid <= 1'b0;
    word_ch.posit_word <= '0;
    burst_left = 0;
    cur_pw = PWIDTH_RESET;
    cur_esd = 6'(ESIZE_RESET);

    dir_rows = '{
      '{6'd32, 6'd2, 32'h0000_0000, 1'b1,
        '{SK_ZERO, 1'b0, 6'd0, 4'd0, 10'd0, 5'd0, 29'd0, ST_SPECIAL}},
      '{6'd32, 6'd2, 32'h8000_0000, 1'b1,
        '{SK_NAR, 1'b1, 6'd0, 4'd0, 10'd0, 5'd0, 29'd0, ST_SPECIAL}},
      '{6'd32, 6'd2, 32'h0000_0001, 1'b1,
        '{SK_ORDINARY, 1'b0, -6'sd30, 4'd0, -10'sd120, 5'd0, 29'd0, ST_OK}},
      '{6'd32, 6'd2, 32'hFFFF_FFFF, 1'b1,
        '{SK_ORDINARY, 1'b1, -6'sd30, 4'd0, -10'sd120, 5'd0, 29'd0, ST_OK}},
      '{6'd32, 6'd2, 32'h7FFF_FFFF, 1'b1,
        '{SK_ORDINARY, 1'b0, 6'd29, 4'd0, 10'd116, 5'd0, 29'd0, ST_MALFORMED}},
      '{6'd32, 6'd2, 32'h4000_0000, 1'b1,
        '{SK_ORDINARY, 1'b0, 6'd0, 4'd0, 10'd0, 5'd27, 29'd0, ST_OK}},
      '{6'd32, 6'd2, 32'hC000_0000, 1'b1,
        '{SK_ORDINARY, 1'b1, 6'd0, 4'd0, 10'd0, 5'd27, 29'd0, ST_OK}},
      '{6'd32, 6'd2, 32'h7FFF_FFFE, 1'b1,
        '{SK_ORDINARY, 1'b0, 6'd29, 4'd0, 10'd116, 5'd0, 29'd0, ST_MALFORMED}},
      '{6'd32, 6'd2, 32'h0000_0002, 1'b0, '0},
      '{6'd32, 6'd2, 32'h0000_0003, 1'b0, '0},
      '{6'd32, 6'd2, 32'h7FFF_FFFD, 1'b0, '0},
      '{6'd32, 6'd2, 32'h3C00_0000, 1'b0, '0},
      '{6'd8, 6'd2, 32'hABCD_EF00, 1'b1,
        '{SK_ZERO, 1'b0, 6'd0, 4'd0, 10'd0, 5'd0, 29'd0, ST_SPECIAL}},
      '{6'd8, 6'd2, 32'h1234_5680, 1'b1,
        '{SK_NAR, 1'b1, 6'd0, 4'd0, 10'd0, 5'd0, 29'd0, ST_SPECIAL}},
      '{6'd8, 6'd2, 32'h0000_00A7, 1'b0, '0},
      '{6'd0, 6'h3F, 32'hFFFF_FFFA, 1'b0, '0},
      '{6'd0, 6'h3F, 32'h0000_0002, 1'b0, '0},
      '{6'd0, 6'h3F, 32'h0000_0003, 1'b0, '0},
      '{6'd63, 6'd4, 32'h7FFF_FFFF, 1'b1,
        '{SK_ORDINARY, 1'b0, 6'd29, 4'd0, 10'd464, 5'd0, 29'd0, ST_MALFORMED}},
      '{6'd63, 6'd4, 32'h0000_0001, 1'b1,
        '{SK_ORDINARY, 1'b0, -6'sd30, 4'd0, -10'sd480, 5'd0, 29'd0, ST_OK}},
      '{6'd63, 6'd4, 32'hA5A5_A5A5, 1'b0, '0},
      '{6'd32, 6'd0, 32'h5FFF_FFFF, 1'b1,
        '{SK_ORDINARY, 1'b0, 6'd0, 4'd0, 10'd0, 5'd29, 29'h1FFF_FFFF, ST_OK}},
      '{6'd32, 6'd0, 32'h2AAA_AAAA, 1'b0, '0},
      '{6'd3, 6'd0, 32'h0000_0005, 1'b0, '0},
      '{6'd3, 6'd0, 32'hFFFF_FFF6, 1'b0, '0}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++) begin
      if (dir_rows[i].pw != cur_pw || dir_rows[i].esd != cur_esd) begin
        drain();
        cfg_write(dir_rows[i].pw, dir_rows[i].esd);
      end
      send(dir_rows[i].word, dir_rows[i].typed ? dir_rows[i].want
           : predict_fields(dir_rows[i].word, cur_pw, cur_esd[ESIZE_W-1:0]));
      pace();
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: cfg_write(6'd3, 6'd0);
        1: cfg_write(6'd32, 6'd4);
        2: cfg_write(6'd63, 6'h3F);
        default: begin
          pw = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(3, 32))
                                          : 6'($urandom_range(0, 63));
          cfg_write(pw, 6'($urandom_range(0, 63)));
        end
      endcase
      ps_eff = (cur_pw < 3) ? 3 : ((cur_pw > 32) ? 32 : int'(cur_pw));
      m64 = (64'd1 << ps_eff) - 64'd1;
      m = m64[WORD_W-1:0];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 4 && n == PHASE_ITEMS / 2) drain();
        w = $urandom;
        sh = $urandom_range(0, 31);
        case ($urandom_range(0, 8))
          0, 1, 2: cand = w;
          3, 4: cand = w >> sh;
          5, 6: cand = ~(w >> sh);
          7: cand = (w >> sh) ^ (32'd1 << (ps_eff - 1));
          default: begin
            case ($urandom_range(0, 5))
              0: cand = '0;
              1: cand = 32'd1 << (ps_eff - 1);
              2: cand = 32'd1;
              3: cand = m;
              4: cand = m >> 1;
              default: cand = 32'd1 << (ps_eff - 2);
            endcase
          end
        endcase
        w = (cand & m) | ($urandom & ~m);
        send(w, predict_fields(w, cur_pw, cur_esd[ESIZE_W-1:0]));
        pace();
      end
    end

    drain();
    if (mismatch_count == 0) begin
      $display("tb_posit_field_unpacker: clean");
    end else begin
      $display("tb_posit_field_unpacker: errors");
    end
    $finish;
  end

endmodule
